FILE: rtl/rgbe_to_rgb9e5_converter_top_assert.svh
// ----------------------------------------------------------------------------
// RGBE to RGB9E5 converter assertion macros
// Concurrent property wrappers used at the end of the converter top level.
// ----------------------------------------------------------------------------
`ifndef RGBE_TO_RGB9E5_CONVERTER_TOP_ASSERT_SVH
`define RGBE_TO_RGB9E5_CONVERTER_TOP_ASSERT_SVH

// check a consequence in the same cycle
`define RGB9E5_ASSERT_NOW(label, cond, res, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (res)) \
      else $error(msg);

// check a delayed consequence
`define RGB9E5_ASSERT_LATER2(label, cond, res, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> ##2 (res)) \
      else $error(msg);

`endif

FILE: rtl/rgb9e5_pkg.sv
// ----------------------------------------------------------------------------
// RGB9E5 converter package
// Constants, shared types and helpers for the RGBE to RGB9E5 datapath.
// ----------------------------------------------------------------------------
package rgb9e5_pkg;

   localparam logic        [8:0] MANT_MAX    = 9'd511;
   localparam logic        [4:0] EXP5_MAX    = 5'd31;
   localparam logic signed [9:0] EXP_OFFSET  = 10'sd122;
   localparam logic signed [9:0] MANT_OFFSET = 10'sd113;
   localparam logic signed [9:0] SHIFT_SAT   = 10'sd9;
   localparam logic        [9:0] SHIFT_ZERO  = 10'd10;

   typedef struct packed {
      logic        [4:0] exp5;
      logic signed [9:0] shift;
   } exp_info_type;

   function automatic logic [3:0] bit_length8(input logic [7:0] value);
      logic [3:0] len;
      len = 4'd0;
      for (int i = 0; i < 8; i++) begin
         if (value[i]) begin
            len = 4'(i + 1);
         end
      end
      return len;
   endfunction

endpackage

FILE: rtl/rgb9e5_exp_calc.sv
// ----------------------------------------------------------------------------
// RGB9E5 shared exponent calculation
// Finds the largest channel, derives the clamped 5-bit exponent and the
// mantissa shift shared by all three channels.
// ----------------------------------------------------------------------------
module rgb9e5_exp_calc (
   input  logic [7:0]                red_in,
   input  logic [7:0]                green_in,
   input  logic [7:0]                blue_in,
   input  logic [7:0]                exp_in,
   output rgb9e5_pkg::exp_info_type  exp_info
);

   logic        [7:0] max_mant;
   logic        [3:0] bit_len;
   logic signed [9:0] exp_raw;
   logic        [4:0] exp5;

   always_comb begin
      max_mant = red_in;
      if (green_in > max_mant) begin
         max_mant = green_in;
      end
      if (blue_in > max_mant) begin
         max_mant = blue_in;
      end
      bit_len = rgb9e5_pkg::bit_length8(max_mant) + 4'd1;
      exp_raw = $signed({6'd0, bit_len}) + $signed({2'd0, exp_in}) - rgb9e5_pkg::EXP_OFFSET;
      if (exp_raw < 10'sd0) begin
         exp5 = 5'd0;
      end else if (exp_raw > $signed({5'd0, rgb9e5_pkg::EXP5_MAX})) begin
         exp5 = rgb9e5_pkg::EXP5_MAX;
      end else begin
         exp5 = exp_raw[4:0];
      end
      exp_info.exp5  = exp5;
      exp_info.shift = $signed({2'd0, exp_in}) - rgb9e5_pkg::MANT_OFFSET
                       - $signed({5'd0, exp5});
   end

endmodule

FILE: rtl/rgb9e5_mant_scale.sv
// ----------------------------------------------------------------------------
// RGB9E5 mantissa scaler
// Scales one odd 9-bit mantissa by a power of two: saturating left shift,
// round-half-up right shift.
// ----------------------------------------------------------------------------
module rgb9e5_mant_scale (
   input  logic [7:0]        mant_in,
   input  logic signed [9:0] shift,
   output logic [8:0]        mant_out
);

   logic [8:0]  odd_mant;
   logic [17:0] wide;
   logic [9:0]  right_amt;
   logic [9:0]  round_sum;

   always_comb begin
      odd_mant  = {mant_in, 1'b1};
      wide      = {9'd0, odd_mant} << shift[3:0];
      right_amt = 10'(-shift);
      round_sum = {1'b0, odd_mant} + (10'd1 << (right_amt[3:0] - 4'd1));
      if (shift >= rgb9e5_pkg::SHIFT_SAT) begin
         mant_out = rgb9e5_pkg::MANT_MAX;
      end else if (shift >= 10'sd0) begin
         if (|wide[17:9]) begin
            mant_out = rgb9e5_pkg::MANT_MAX;
         end else begin
            mant_out = wide[8:0];
         end
      end else if (right_amt >= rgb9e5_pkg::SHIFT_ZERO) begin
         mant_out = 9'd0;
      end else begin
         mant_out = 9'(round_sum >> right_amt[3:0]);
      end
   end

endmodule

FILE: rtl/rgbe_to_rgb9e5_converter_top.sv
// ----------------------------------------------------------------------------
// RGBE to RGB9E5 converter top level
// Converts one RGBE pixel per cycle into shared-exponent E5B9G9R9 fields.
//
// Input: a pixel is taken on a rising edge with start high and busy low.
// busy is held low, so a pixel may be offered in every cycle.
// Output: rsp_valid is high for exactly one cycle with the converted
// exponent and three mantissas; the receiver cannot hold results off.
// An accepted pixel passes the input register, then the result register,
// which drives the outputs.
// Throughput: one pixel per cycle, set by the single pass of exponent
// search, clamp and barrel shift between the two register stages.
// Reset: synchronous, active high; clears both valid flags, so no result
// is shown after reset until a new pixel has been accepted.
// ----------------------------------------------------------------------------
`include "rgbe_to_rgb9e5_converter_top_assert.svh"

module rgbe_to_rgb9e5_converter_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_red_in,
   input  logic [7:0] req_green_in,
   input  logic [7:0] req_blue_in,
   input  logic [7:0] req_exp_in,
   output logic       rsp_valid,
   output logic [4:0] rsp_exp_out,
   output logic [8:0] rsp_blue_out,
   output logic [8:0] rsp_green_out,
   output logic [8:0] rsp_red_out
);

   logic                     in_valid_ff;
   logic                     in_valid_in;
   logic [7:0]               red_ff;
   logic [7:0]               green_ff;
   logic [7:0]               blue_ff;
   logic [7:0]               exp_ff;
   rgb9e5_pkg::exp_info_type exp_info;
   logic [8:0]               red_scaled;
   logic [8:0]               green_scaled;
   logic [8:0]               blue_scaled;
   logic                     out_valid_ff;
   logic [4:0]               exp_out_ff;
   logic [8:0]               blue_out_ff;
   logic [8:0]               green_out_ff;
   logic [8:0]               red_out_ff;

   assign busy        = 1'b0;
   assign in_valid_in = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_in) begin
         red_ff   <= req_red_in;
         green_ff <= req_green_in;
         blue_ff  <= req_blue_in;
         exp_ff   <= req_exp_in;
      end
      if (in_valid_ff) begin
         exp_out_ff   <= exp_info.exp5;
         blue_out_ff  <= blue_scaled;
         green_out_ff <= green_scaled;
         red_out_ff   <= red_scaled;
      end
   end

   rgb9e5_exp_calc u_exp_calc (
      .red_in   (red_ff),
      .green_in (green_ff),
      .blue_in  (blue_ff),
      .exp_in   (exp_ff),
      .exp_info (exp_info)
   );

   rgb9e5_mant_scale u_scale_red (
      .mant_in  (red_ff),
      .shift    (exp_info.shift),
      .mant_out (red_scaled)
   );

   rgb9e5_mant_scale u_scale_green (
      .mant_in  (green_ff),
      .shift    (exp_info.shift),
      .mant_out (green_scaled)
   );

   rgb9e5_mant_scale u_scale_blue (
      .mant_in  (blue_ff),
      .shift    (exp_info.shift),
      .mant_out (blue_scaled)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_exp_out   = exp_out_ff;
   assign rsp_blue_out  = blue_out_ff;
   assign rsp_green_out = green_out_ff;
   assign rsp_red_out   = red_out_ff;

   `RGB9E5_ASSERT_LATER2(a_accept_gives_result, start && !busy, rsp_valid, "accepted pixel gave no result")
   `RGB9E5_ASSERT_NOW(a_result_has_source, rsp_valid, $past(start && !busy, 2), "result without an accepted pixel")
   `RGB9E5_ASSERT_NOW(a_normalized_mantissa, rsp_valid && rsp_exp_out != 5'd0 && rsp_exp_out != rgb9e5_pkg::EXP5_MAX, rsp_red_out[8] || rsp_green_out[8] || rsp_blue_out[8], "unclamped exponent with unnormalized mantissas")

endmodule
